FILE: rtl/kws_pkg.sv
// kws_pkg: constants shared by the keyword substitution cipher
// holds letter count, ascii bounds and command codes; depends on nothing

package kws_pkg;

    // alphabet size and letter index width
    localparam int unsigned LETTERS   = 26;
    localparam int unsigned LETTER_AW = 5;

    // ascii bounds
    localparam logic [7:0] CHAR_LA = 8'h61;
    localparam logic [7:0] CHAR_LZ = 8'h7a;
    localparam logic [7:0] CHAR_UA = 8'h41;
    localparam logic [7:0] CHAR_UZ = 8'h5a;

    // command codes
    localparam logic [2:0] CMD_CLEAR   = 3'd0;
    localparam logic [2:0] CMD_KEY     = 3'd1;
    localparam logic [2:0] CMD_FINISH  = 3'd2;
    localparam logic [2:0] CMD_ENCRYPT = 3'd3;
    localparam logic [2:0] CMD_DECRYPT = 3'd4;

    // what the result stage does with a request
    typedef enum logic [1:0] {
        KIND_PASS,
        KIND_ENC,
        KIND_DEC
    } kind_t;

endpackage

FILE: rtl/kws_ram.sv
// kws_ram: generic single write port, single read port ram
// registered read with read enable, read returns old data on collision; no dependencies

module kws_ram #(
    parameter int unsigned WIDTH = 5,
    parameter int unsigned DEPTH = 26
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port, holds when not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: rtl/keyword_substitution_cipher.sv
// keyword_substitution_cipher: keyword monoalphabetic substitution cipher
// uses kws_pkg for constants and two kws_ram instances for the forward and reverse tables
//
//   channel  signals                     direction  contents
//   in       in_valid, in_stall          request    command, char_in
//   out      out_valid, out_stall        result     char_out
//
// encrypt and decrypt stream one per cycle while the output is not stalled; a result
// passes through the table read, then the output register. finish walks the alphabet
// into the forward table, reads the forward table back and then does the last reverse
// table write before the next request is taken.
// table entries never written since reset read as the identity mapping (valid bits).
// in_stall is high during finish and while a result waits behind a stalled output.

module keyword_substitution_cipher
    import kws_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [2:0] command,
    input  logic [7:0] char_in,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] char_out
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FILL,
        ST_REV,
        ST_DRAIN
    } state_t;

    localparam logic [LETTER_AW-1:0] LAST_IDX = LETTER_AW'(LETTERS - 1);
    localparam logic [LETTER_AW-1:0] FULL_LEN = LETTER_AW'(LETTERS);

    state_t                 state_reg;
    logic [LETTER_AW-1:0]   cnt_reg;
    logic [LETTER_AW-1:0]   pos_reg;
    logic [LETTERS-1:0]     used_reg;
    logic [LETTER_AW-1:0]   kl_reg;
    logic [LETTERS-1:0]     fwd_ok_reg;
    logic [LETTERS-1:0]     rev_ok_reg;
    logic                   fwd_rok_reg;
    logic                   rev_rok_reg;
    logic [LETTER_AW-1:0]   fwd_raddr_reg;
    logic [LETTER_AW-1:0]   rev_raddr_reg;
    logic                   wr_pend_reg;
    logic                   s1_valid_reg;
    kind_t                  s1_kind_reg;
    logic [7:0]             s1_char_reg;
    logic                   o_valid_reg;
    logic [7:0]             o_char_reg;

    logic                   in_accept;
    logic                   s1_adv;
    logic                   is_lower;
    logic                   is_upper;
    logic [7:0]             lo_diff;
    logic [7:0]             up_diff;
    logic [LETTER_AW-1:0]   lo_idx;
    logic [LETTER_AW-1:0]   up_idx;
    logic                   key_take;
    logic                   fill_write;
    logic                   fwd_we;
    logic [LETTER_AW-1:0]   fwd_waddr;
    logic [LETTER_AW-1:0]   fwd_wdata;
    logic                   fwd_re;
    logic [LETTER_AW-1:0]   fwd_raddr;
    logic [LETTER_AW-1:0]   fwd_rdata;
    logic [LETTER_AW-1:0]   fwd_val;
    logic                   rev_we;
    logic                   rev_re;
    logic [LETTER_AW-1:0]   rev_rdata;
    logic [LETTER_AW-1:0]   rev_val;
    kind_t                  kind_next;
    logic [7:0]             o_char_next;

    // handshake
    assign s1_adv    = !o_valid_reg || !out_stall;
    assign in_stall  = (state_reg != ST_IDLE) || (s1_valid_reg && !s1_adv);
    assign in_accept = in_valid && !in_stall;
    assign out_valid = o_valid_reg;
    assign char_out  = o_char_reg;

    // letter classification and indexes
    assign is_lower = (char_in >= CHAR_LA) && (char_in <= CHAR_LZ);
    assign is_upper = (char_in >= CHAR_UA) && (char_in <= CHAR_UZ);
    assign lo_diff  = char_in - CHAR_LA;
    assign up_diff  = char_in - CHAR_UA;
    assign lo_idx   = lo_diff[LETTER_AW-1:0];
    assign up_idx   = up_diff[LETTER_AW-1:0];

    // new key letter appended at the current key length
    assign key_take = in_accept && (command == CMD_KEY) && is_upper
                      && !used_reg[up_idx] && (kl_reg < FULL_LEN);

    // forward table ports
    assign fill_write = (state_reg == ST_FILL) && !used_reg[cnt_reg];
    assign fwd_we     = key_take || fill_write;
    assign fwd_waddr  = (state_reg == ST_FILL) ? pos_reg : kl_reg;
    assign fwd_wdata  = (state_reg == ST_FILL) ? cnt_reg : up_idx;
    assign fwd_re     = (in_accept && (command == CMD_ENCRYPT) && is_lower)
                        || (state_reg == ST_REV);
    assign fwd_raddr  = (state_reg == ST_REV) ? cnt_reg : lo_idx;
    assign fwd_val    = fwd_rok_reg ? fwd_rdata : fwd_raddr_reg;

    // reverse table ports, written in the cycle after each forward read in the rebuild
    assign rev_we  = wr_pend_reg;
    assign rev_re  = in_accept && (command == CMD_DECRYPT) && is_upper;
    assign rev_val = rev_rok_reg ? rev_rdata : rev_raddr_reg;

    kws_ram #(
        .WIDTH (LETTER_AW),
        .DEPTH (LETTERS)
    ) u_fwd_ram (
        .clk   (clk),
        .we    (fwd_we),
        .waddr (fwd_waddr),
        .wdata (fwd_wdata),
        .re    (fwd_re),
        .raddr (fwd_raddr),
        .rdata (fwd_rdata)
    );

    kws_ram #(
        .WIDTH (LETTER_AW),
        .DEPTH (LETTERS)
    ) u_rev_ram (
        .clk   (clk),
        .we    (rev_we),
        .waddr (fwd_val),
        .wdata (fwd_raddr_reg),
        .re    (rev_re),
        .raddr (up_idx),
        .rdata (rev_rdata)
    );

    // kind of the accepted request
    always_comb
    begin
        kind_next = KIND_PASS;
        if ((command == CMD_ENCRYPT) && is_lower)
        begin
            kind_next = KIND_ENC;
        end
        else if ((command == CMD_DECRYPT) && is_upper)
        begin
            kind_next = KIND_DEC;
        end
    end

    // result byte from the table read
    always_comb
    begin
        case (s1_kind_reg)
            KIND_ENC: o_char_next = CHAR_UA + {3'b000, fwd_val};
            KIND_DEC: o_char_next = CHAR_LA + {3'b000, rev_val};
            default:  o_char_next = s1_char_reg;
        endcase
    end

    // control state, key state, valid bits and the finish sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            pos_reg      <= '0;
            used_reg     <= '0;
            kl_reg       <= '0;
            fwd_ok_reg   <= '0;
            rev_ok_reg   <= '0;
            wr_pend_reg  <= 1'b0;
            s1_valid_reg <= 1'b0;
            o_valid_reg  <= 1'b0;
        end
        else
        begin
            // pipeline valids
            if (s1_adv)
            begin
                o_valid_reg <= s1_valid_reg;
            end
            if (in_accept)
            begin
                s1_valid_reg <= (command == CMD_ENCRYPT) || (command == CMD_DECRYPT);
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end

            // table entry valid bits
            if (fwd_we)
            begin
                fwd_ok_reg[fwd_waddr] <= 1'b1;
            end
            if (rev_we)
            begin
                rev_ok_reg[fwd_val] <= 1'b1;
            end

            // key entry
            if (in_accept && (command == CMD_CLEAR))
            begin
                used_reg <= '0;
                kl_reg   <= '0;
            end
            if (key_take)
            begin
                used_reg[up_idx] <= 1'b1;
                kl_reg           <= kl_reg + 1'b1;
            end

            wr_pend_reg <= (state_reg == ST_REV);

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_accept && (command == CMD_FINISH))
                    begin
                        state_reg <= ST_FILL;
                        cnt_reg   <= '0;
                        pos_reg   <= kl_reg;
                    end
                end
                // walk letters in order, placing unused ones after the key
                ST_FILL:
                begin
                    if (fill_write)
                    begin
                        pos_reg <= pos_reg + 1'b1;
                    end
                    if (cnt_reg == LAST_IDX)
                    begin
                        state_reg <= ST_REV;
                        cnt_reg   <= '0;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                // read every forward entry, the reverse write follows in the cycle after
                ST_REV:
                begin
                    if (cnt_reg == LAST_IDX)
                    begin
                        state_reg <= ST_DRAIN;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                ST_DRAIN:
                begin
                    state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (fwd_re)
        begin
            fwd_raddr_reg <= fwd_raddr;
            fwd_rok_reg   <= fwd_ok_reg[fwd_raddr];
        end
        if (rev_re)
        begin
            rev_raddr_reg <= up_idx;
            rev_rok_reg   <= rev_ok_reg[up_idx];
        end
        if (in_accept)
        begin
            s1_kind_reg <= kind_next;
            s1_char_reg <= char_in;
        end
        if (s1_adv && s1_valid_reg)
        begin
            o_char_reg <= o_char_next;
        end
    end

endmodule
